/* hw/rtl/riq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riq_pkg
// Shared widths, register codes, reset values and helpers for the box-in-quad
// ray casting block.
// ----------------------------------------------------------------------------
package riq_pkg;

  localparam int COORD_BITS = 10;
  localparam int RAY_LENGTH = 1000;
  localparam int RAY_BITS   = 12;

  // corner coordinate (x+w does not wrap)
  localparam int CW  = COORD_BITS + 1;
  // signed corner minus vertex
  localparam int DW  = COORD_BITS + 2;
  // signed vertex minus vertex
  localparam int EW  = COORD_BITS + 1;
  // signed product of an edge delta and a corner delta
  localparam int PW  = EW + DW;
  // numerator (difference of two products)
  localparam int NW  = PW + 1;
  // denominator (ray length times edge y delta)
  localparam int DNW = EW + RAY_BITS + 1;
  // common compare width
  localparam int KW  = ((NW > DNW) ? NW : DNW) + 1;

  localparam int NUM_CORNERS = 4;
  localparam int NUM_EDGES   = 4;
  localparam int NUM_VERTS   = 4;
  localparam int CNT_W       = 3;
  localparam int HIT_W       = 3;
  localparam int MIN_CORNERS = 2;

  localparam logic signed [RAY_BITS:0] RAY_S = (RAY_BITS + 1)'(RAY_LENGTH);

  // edges as vertex pairs: 0-1, 0-2, 1-3, 2-3
  localparam int EDGE_A [NUM_EDGES] = '{0, 0, 1, 2};
  localparam int EDGE_B [NUM_EDGES] = '{1, 2, 3, 3};

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0_X = 4'd0,
    REG_V0_Y = 4'd1,
    REG_V1_X = 4'd2,
    REG_V1_Y = 4'd3,
    REG_V2_X = 4'd4,
    REG_V2_Y = 4'd5,
    REG_V3_X = 4'd6,
    REG_V3_Y = 4'd7
  } cfg_reg_t;

  localparam logic [COORD_BITS-1:0] RST_V0_X = COORD_BITS'(680);
  localparam logic [COORD_BITS-1:0] RST_V0_Y = COORD_BITS'(240);
  localparam logic [COORD_BITS-1:0] RST_V1_X = COORD_BITS'(357);
  localparam logic [COORD_BITS-1:0] RST_V1_Y = COORD_BITS'(66);
  localparam logic [COORD_BITS-1:0] RST_V2_X = COORD_BITS'(40);
  localparam logic [COORD_BITS-1:0] RST_V2_Y = COORD_BITS'(290);
  localparam logic [COORD_BITS-1:0] RST_V3_X = COORD_BITS'(340);
  localparam logic [COORD_BITS-1:0] RST_V3_Y = COORD_BITS'(450);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vtx_t;

  typedef vtx_t [NUM_VERTS-1:0] vtx_arr_t;

  // true when n/d lies in [0,1], d nonzero, decided without division
  function automatic logic ratio_in_unit(input logic signed [KW-1:0] n,
                                         input logic signed [KW-1:0] d);
    logic res;
    res = 1'b0;
    if (d > 0) begin
      res = (n >= 0) && (n <= d);
    end else if (d < 0) begin
      res = (n <= 0) && (n >= d);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/riq_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riq channel interfaces
// Valid/ready channels for boxes, results and register writes.
// ----------------------------------------------------------------------------
interface riq_in_if;
  import riq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;

  modport source (output valid, box_x, box_y, box_width, box_height, input ready);
  modport sink   (input valid, box_x, box_y, box_width, box_height, output ready);
endinterface

interface riq_out_if;
  import riq_pkg::*;

  logic             valid;
  logic             ready;
  logic             box_inside;
  logic [3:0]       corner_mask;
  logic [CNT_W-1:0] corners_inside;

  modport source (output valid, box_inside, corner_mask, corners_inside, input ready);
  modport sink   (input valid, box_inside, corner_mask, corners_inside, output ready);
endinterface

interface riq_cfg_if;
  import riq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [COORD_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/rect_in_quad_ray_cast.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_in_quad_ray_cast
// Box-in-quadrilateral test by horizontal ray casting from the box corners.
// ----------------------------------------------------------------------------
// Takes one box item per cycle while the pipeline advances and returns one
// result item per box from the stage 4 registers. The four-stage pipeline
// holds one item per stage, so a box can enter in every cycle; the
// whole pipeline advances together and freezes while a finished result waits
// on out_ch.ready, so nothing is lost or repeated. Stages: (1) form the corners
// and the corner-to-vertex deltas for all sixteen corner/edge pairs, (2) the
// two cross products per pair in parallel multipliers, (3) the exact inclusive
// parameter tests against ray length times edge y delta, (4) count edge hits
// per corner and register the result. Horizontal edges never count as crossed.
// Vertex registers reset to the default quadrilateral and are written through
// cfg_ch, which is always ready; write them only while no box is in flight.
// ----------------------------------------------------------------------------
module rect_in_quad_ray_cast (
  input  logic    clk,
  input  logic    rst_n,
  riq_in_if.sink  in_ch,
  riq_out_if.source out_ch,
  riq_cfg_if.sink cfg_ch
);
  import riq_pkg::*;

  vtx_arr_t vtx;

  riq_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .vtx    (vtx)
  );

  // advance the whole pipeline unless the output register is full and stalled
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;

  assign adv         = !v4_r || out_ch.ready;
  assign in_ch.ready = adv;

  // edge deltas and denominators follow the vertex registers
  logic signed [EW-1:0]  edge_dx  [NUM_EDGES];
  logic signed [EW-1:0]  edge_dy  [NUM_EDGES];
  logic signed [KW-1:0]  edge_den [NUM_EDGES];

  always_comb begin
    for (int j = 0; j < NUM_EDGES; j++) begin
      edge_dx[j]  = $signed({1'b0, vtx[EDGE_B[j]].x}) - $signed({1'b0, vtx[EDGE_A[j]].x});
      edge_dy[j]  = $signed({1'b0, vtx[EDGE_B[j]].y}) - $signed({1'b0, vtx[EDGE_A[j]].y});
      edge_den[j] = KW'(RAY_S) * KW'(edge_dy[j]);
    end
  end

  // stage 1: corners, deltas and ray parameter tests
  logic [CW-1:0]         cx [NUM_CORNERS];
  logic [CW-1:0]         cy [NUM_CORNERS];
  logic signed [DW-1:0]  ex_nxt [NUM_CORNERS][NUM_EDGES];
  logic signed [DW-1:0]  ey_nxt [NUM_CORNERS][NUM_EDGES];
  logic                  nb_nxt [NUM_CORNERS][NUM_EDGES];
  logic signed [DW-1:0]  ex_r   [NUM_CORNERS][NUM_EDGES];
  logic signed [DW-1:0]  ey_r   [NUM_CORNERS][NUM_EDGES];
  logic                  nb1_r  [NUM_CORNERS][NUM_EDGES];

  always_comb begin
    cx[0] = {1'b0, in_ch.box_x};
    cy[0] = {1'b0, in_ch.box_y};
    cx[1] = {1'b0, in_ch.box_x} + {1'b0, in_ch.box_width};
    cy[1] = {1'b0, in_ch.box_y};
    cx[2] = {1'b0, in_ch.box_x};
    cy[2] = {1'b0, in_ch.box_y} + {1'b0, in_ch.box_height};
    cx[3] = {1'b0, in_ch.box_x} + {1'b0, in_ch.box_width};
    cy[3] = {1'b0, in_ch.box_y} + {1'b0, in_ch.box_height};
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int j = 0; j < NUM_EDGES; j++) begin
        ex_nxt[i][j] = $signed({1'b0, cx[i]}) - $signed({2'b00, vtx[EDGE_A[j]].x});
        ey_nxt[i][j] = $signed({1'b0, cy[i]}) - $signed({2'b00, vtx[EDGE_A[j]].y});
        // ray parameter test reduces to (py-ay)/(by-ay) in [0,1]
        nb_nxt[i][j] = ratio_in_unit(KW'(ey_nxt[i][j]), KW'(edge_dy[j]));
      end
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] m1_nxt [NUM_CORNERS][NUM_EDGES];
  logic signed [PW-1:0] m2_nxt [NUM_CORNERS][NUM_EDGES];
  logic signed [PW-1:0] m1_r   [NUM_CORNERS][NUM_EDGES];
  logic signed [PW-1:0] m2_r   [NUM_CORNERS][NUM_EDGES];
  logic                 nb2_r  [NUM_CORNERS][NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int j = 0; j < NUM_EDGES; j++) begin
        m1_nxt[i][j] = PW'(edge_dy[j]) * PW'(ex_r[i][j]);
        m2_nxt[i][j] = PW'(edge_dx[j]) * PW'(ey_r[i][j]);
      end
    end
  end

  // stage 3: edge parameter test and hit bits
  logic signed [KW-1:0] na [NUM_CORNERS][NUM_EDGES];
  logic [NUM_EDGES-1:0] hit_nxt [NUM_CORNERS];
  logic [NUM_EDGES-1:0] hit_r   [NUM_CORNERS];

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int j = 0; j < NUM_EDGES; j++) begin
        na[i][j]         = KW'(m2_r[i][j]) - KW'(m1_r[i][j]);
        hit_nxt[i][j]    = nb2_r[i][j] && ratio_in_unit(na[i][j], edge_den[j]);
      end
    end
  end

  // stage 4: per-corner counts and box verdict
  logic [HIT_W-1:0]       hits [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] mask_nxt;
  logic [CNT_W-1:0]       cnt_nxt;
  logic                   inside_nxt;
  logic [NUM_CORNERS-1:0] mask_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   inside_r;

  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      hits[i] = '0;
      for (int j = 0; j < NUM_EDGES; j++) begin
        hits[i] = hits[i] + HIT_W'(hit_r[i][j]);
      end
      mask_nxt[i] = (hits[i] == HIT_W'(1));
      cnt_nxt     = cnt_nxt + CNT_W'(mask_nxt[i]);
    end
    inside_nxt = (cnt_nxt >= CNT_W'(MIN_CORNERS));
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload: hold on stall, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        for (int j = 0; j < NUM_EDGES; j++) begin
          ex_r[i][j]  <= ex_nxt[i][j];
          ey_r[i][j]  <= ey_nxt[i][j];
          nb1_r[i][j] <= nb_nxt[i][j];
          m1_r[i][j]  <= m1_nxt[i][j];
          m2_r[i][j]  <= m2_nxt[i][j];
          nb2_r[i][j] <= nb1_r[i][j];
        end
        hit_r[i] <= hit_nxt[i];
      end
      mask_r   <= mask_nxt;
      cnt_r    <= cnt_nxt;
      inside_r <= inside_nxt;
    end
  end

  assign out_ch.valid          = v4_r;
  assign out_ch.box_inside     = inside_r;
  assign out_ch.corner_mask    = mask_r;
  assign out_ch.corners_inside = cnt_r;

endmodule

/* hw/rtl/riq_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riq_cfg_regs
// Quadrilateral vertex registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module riq_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  riq_cfg_if.sink           cfg_ch,
  output riq_pkg::vtx_arr_t vtx
);
  import riq_pkg::*;

  vtx_arr_t vtx_r;

  assign cfg_ch.ready = 1'b1;
  assign vtx          = vtx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_r[0].x <= RST_V0_X;
      vtx_r[0].y <= RST_V0_Y;
      vtx_r[1].x <= RST_V1_X;
      vtx_r[1].y <= RST_V1_Y;
      vtx_r[2].x <= RST_V2_X;
      vtx_r[2].y <= RST_V2_Y;
      vtx_r[3].x <= RST_V3_X;
      vtx_r[3].y <= RST_V3_Y;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_V0_X: vtx_r[0].x <= cfg_ch.data;
        REG_V0_Y: vtx_r[0].y <= cfg_ch.data;
        REG_V1_X: vtx_r[1].x <= cfg_ch.data;
        REG_V1_Y: vtx_r[1].y <= cfg_ch.data;
        REG_V2_X: vtx_r[2].x <= cfg_ch.data;
        REG_V2_Y: vtx_r[2].y <= cfg_ch.data;
        REG_V3_X: vtx_r[3].x <= cfg_ch.data;
        REG_V3_Y: vtx_r[3].y <= cfg_ch.data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

endmodule

/* dv/riq_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riq_tb_pkg
// Item types and the result scoreboard for the box-in-quad ray casting bench.
// ----------------------------------------------------------------------------
package riq_tb_pkg;
  import riq_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef struct packed {
    logic             in_quad;
    logic [3:0]       mask;
    logic [CNT_W-1:0] count;
  } verdict_t;

  // register indexes from here up select no register
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(2 * NUM_VERTS);
  localparam int REPORT_LIMIT = 10;

  class box_verdict_board;
    logic [COORD_BITS-1:0] vx [NUM_VERTS];
    logic [COORD_BITS-1:0] vy [NUM_VERTS];
    verdict_t    verdicts_due [$];
    int unsigned checked;
    int unsigned inside_seen;
    int unsigned errors;

    function new();
      vx = '{RST_V0_X, RST_V1_X, RST_V2_X, RST_V3_X};
      vy = '{RST_V0_Y, RST_V1_Y, RST_V2_Y, RST_V3_Y};
      checked     = 0;
      inside_seen = 0;
      errors      = 0;
    endfunction

    function void write_vertex(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] data);
      case (idx)
        REG_V0_X: vx[0] = data;
        REG_V0_Y: vy[0] = data;
        REG_V1_X: vx[1] = data;
        REG_V1_Y: vy[1] = data;
        REG_V2_X: vx[2] = data;
        REG_V2_Y: vy[2] = data;
        REG_V3_X: vx[3] = data;
        REG_V3_Y: vy[3] = data;
        default: ;
      endcase
    endfunction

    // n/d within [0,1] inclusive, d known to be nonzero
    function bit within_unit(longint n, longint d);
      if (d > 0) begin
        return (n >= 0) && (n <= d);
      end
      return (n <= 0) && (n >= d);
    endfunction

    // horizontal ray of RAY_LENGTH from each corner against every edge
    function verdict_t cast_rays(box_t b);
      verdict_t v;
      longint   px, py, ax, ay, ex, ey, na, nb, den;
      int       c, e, hits;
      v = '0;
      for (c = 0; c < NUM_CORNERS; c++) begin
        px   = longint'(b.x) + (((c & 1) != 0) ? longint'(b.w) : 64'sd0);
        py   = longint'(b.y) + (((c & 2) != 0) ? longint'(b.h) : 64'sd0);
        hits = 0;
        for (e = 0; e < NUM_EDGES; e++) begin
          ax  = longint'(vx[EDGE_A[e]]);
          ay  = longint'(vy[EDGE_A[e]]);
          ex  = longint'(vx[EDGE_B[e]]);
          ey  = longint'(vy[EDGE_B[e]]);
          na  = (ay - ey) * (px - ax) + (ex - ax) * (py - ay);
          nb  = RAY_LENGTH * (py - ay);
          den = RAY_LENGTH * (ey - ay);
          if (den != 0 && within_unit(na, den) && within_unit(nb, den)) begin
            hits++;
          end
        end
        if (hits == 1) begin
          v.mask[c] = 1'b1;
          v.count   = v.count + 1'b1;
        end
      end
      v.in_quad = (v.count >= MIN_CORNERS);
      return v;
    endfunction

    function void note_box(box_t b);
      verdicts_due.insert(verdicts_due.size(), cast_rays(b));
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void check_verdict(logic box_in, logic [3:0] mask,
                                logic [CNT_W-1:0] count);
      verdict_t exp_v;
      bit       bad;
      checked++;
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("[%0t] result with nothing outstanding: inside=%0d mask=%b count=%0d",
                   $realtime, box_in, mask, count);
        end
        return;
      end
      exp_v = verdicts_due.pop_front();
      if (exp_v.in_quad) inside_seen++;
      bad = (box_in !== exp_v.in_quad) || (mask !== exp_v.mask) ||
            (count !== exp_v.count);
      if (bad) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("[%0t] result mismatch: expected inside=%0d mask=%b count=%0d,",
                   $realtime, exp_v.in_quad, exp_v.mask, exp_v.count);
          $display("    got inside=%0d mask=%b count=%0d", box_in, mask, count);
        end
      end
    endfunction
  endclass

endpackage

/* dv/tb_rect_in_quad_ray_cast.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_in_quad_ray_cast
// Self-checking bench for the box-in-quadrilateral ray casting block.
// ----------------------------------------------------------------------------
// Boxes go in over the input channel; every accepted box is run through an
// in-bench ray caster against a mirrored copy of the vertex registers and the
// predicted verdict is queued. Each result item is checked field by field
// against the oldest queued verdict. A directed opener covers field extremes,
// corners sitting on vertices, a full-range square, a degenerate edge and a
// horizontal edge; then nine random phases each load a fresh quadrilateral and
// push boxes through under varying back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_rect_in_quad_ray_cast;
  import riq_pkg::*;
  import riq_tb_pkg::*;

  localparam int PIPE_LATENCY    = 4;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int LONG_HOLD       = 48;

  typedef enum int {
    QUAD_RESET,
    QUAD_CONVEX,
    QUAD_RANDOM,
    QUAD_SQUARE,
    QUAD_ZERO,
    QUAD_MAX,
    QUAD_FLAT
  } quad_kind_t;

  // quadrilateral loaded at the start of each random phase
  localparam quad_kind_t PHASE_QUAD [NUM_PHASES] = '{
    QUAD_RESET, QUAD_CONVEX, QUAD_SQUARE,
    QUAD_RANDOM, QUAD_CONVEX, QUAD_ZERO,
    QUAD_CONVEX, QUAD_RANDOM, QUAD_MAX
  };

  localparam cfg_reg_t X_REG [NUM_VERTS] = '{REG_V0_X, REG_V1_X, REG_V2_X, REG_V3_X};
  localparam cfg_reg_t Y_REG [NUM_VERTS] = '{REG_V0_Y, REG_V1_Y, REG_V2_Y, REG_V3_Y};

  localparam logic [COORD_BITS-1:0] CMAX = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int          send_idle_pct = 16;
  int          recv_idle_pct = 60;
  int          hold_left     = 0;
  int unsigned boxes_sent    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned quads_loaded  = 0;

  box_verdict_board sb;

  riq_in_if  in_ch ();
  riq_out_if out_ch ();
  riq_cfg_if cfg_ch ();

  rect_in_quad_ray_cast uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the handshakes lock up.
  initial begin
    #2_000_000;
    $display("rect_in_quad_ray_cast test failed");
    $finish;
  end

  // Result side: drive ready at the falling edge. A pending hold-off keeps
  // ready low until it has counted down, so the pipeline backs up into the input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left    = hold_left - 1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check each result item as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_verdict(out_ch.box_inside, out_ch.corner_mask, out_ch.corners_inside);
    end
  end

  function automatic box_t mk_box(int x, int y, int w, int h);
    box_t b;
    b.x = COORD_BITS'(x);
    b.y = COORD_BITS'(y);
    b.w = COORD_BITS'(w);
    b.h = COORD_BITS'(h);
    return b;
  endfunction

  // Offer one box from a falling edge; hold it until taken, then drop valid
  // at the next falling edge so a caller that waits never repeats the item.
  task automatic send_box(input box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid      = 1'b0;
      in_ch.box_x      = COORD_BITS'($urandom);
      in_ch.box_y      = COORD_BITS'($urandom);
      in_ch.box_width  = COORD_BITS'($urandom);
      in_ch.box_height = COORD_BITS'($urandom);
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.box_x      = b.x;
    in_ch.box_y      = b.y;
    in_ch.box_width  = b.w;
    in_ch.box_height = b.h;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_box(b);
    boxes_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_BITS-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_vertex(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Wait for every queued verdict, then let the pipeline settle.
  task automatic wait_drained(input int settle);
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Load all eight vertex registers, with one write to an unused index
  // dropped in at a random point; that write must change nothing.
  task automatic set_quad(input int qx [NUM_VERTS], input int qy [NUM_VERTS]);
    int junk_at;
    int k;
    junk_at = $urandom_range(NUM_VERTS);
    for (k = 0; k <= NUM_VERTS; k++) begin
      if (k == junk_at) begin
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(7)), COORD_BITS'($urandom));
      end
      if (k < NUM_VERTS) begin
        write_reg(X_REG[k], COORD_BITS'(qx[k]));
        write_reg(Y_REG[k], COORD_BITS'(qy[k]));
      end
    end
    cfg_ch.valid = 1'b0;
    quads_loaded++;
  endtask

  task automatic pick_quad(input quad_kind_t kind,
                           output int qx [NUM_VERTS], output int qy [NUM_VERTS]);
    int cx, cy, r, k;
    case (kind)
      QUAD_RESET: begin
        qx = '{RST_V0_X, RST_V1_X, RST_V2_X, RST_V3_X};
        qy = '{RST_V0_Y, RST_V1_Y, RST_V2_Y, RST_V3_Y};
      end
      QUAD_CONVEX: begin
        // right, top, left, bottom around a random centre: edges 0-1 and 2-3
        // trace outline sides, while edges 0-2 and 1-3 cross the outline as diagonals
        cx = $urandom_range(783, 240);
        cy = $urandom_range(783, 240);
        r  = $urandom_range(199, 50);
        qx[0] = cx + r;                         qy[0] = cy + $urandom_range(80) - 40;
        r  = $urandom_range(199, 50);
        qx[1] = cx + $urandom_range(80) - 40;   qy[1] = cy - r;
        r  = $urandom_range(199, 50);
        qx[2] = cx - r;                         qy[2] = cy + $urandom_range(80) - 40;
        r  = $urandom_range(199, 50);
        qx[3] = cx + $urandom_range(80) - 40;   qy[3] = cy + r;
      end
      QUAD_SQUARE: begin
        qx = '{0, CMAX, 0, CMAX};
        qy = '{0, 0, CMAX, CMAX};
      end
      QUAD_ZERO: begin
        qx = '{0, 0, 0, 0};
        qy = '{0, 0, 0, 0};
      end
      QUAD_MAX: begin
        qx = '{CMAX, CMAX, CMAX, CMAX};
        qy = '{CMAX, CMAX, CMAX, CMAX};
      end
      QUAD_FLAT: begin
        // edge 0-1 collapses to a point, edge 0-2 runs along the ray
        qx = '{500, 500, 100, 100};
        qy = '{500, 500, 500, 900};
      end
      default: begin
        for (k = 0; k < NUM_VERTS; k++) begin
          qx[k] = $urandom_range(CMAX);
          qy[k] = $urandom_range(CMAX);
        end
      end
    endcase
  endtask

  // Mostly small boxes over the quad's bounding box, so corners land on
  // either side of the edges; the rest are corners on vertex rows, fully
  // random boxes and field extremes.
  function automatic box_t random_box();
    box_t        b;
    int unsigned mode;
    int          xlo, xhi, ylo, yhi, k;
    xlo = CMAX; xhi = 0; ylo = CMAX; yhi = 0;
    for (k = 0; k < NUM_VERTS; k++) begin
      if (sb.vx[k] < xlo) xlo = sb.vx[k];
      if (sb.vx[k] > xhi) xhi = sb.vx[k];
      if (sb.vy[k] < ylo) ylo = sb.vy[k];
      if (sb.vy[k] > yhi) yhi = sb.vy[k];
    end
    mode = $urandom_range(99);
    if (mode < 55) begin
      b.x = COORD_BITS'($urandom_range(xhi, xlo));
      b.y = COORD_BITS'($urandom_range(yhi, ylo));
      b.w = COORD_BITS'($urandom_range(($urandom_range(3) == 0) ? 255 : 40));
      b.h = COORD_BITS'($urandom_range(($urandom_range(3) == 0) ? 255 : 40));
    end else if (mode < 70) begin
      // put the top or bottom row exactly on a vertex row to touch endpoints
      k   = $urandom_range(NUM_VERTS - 1);
      b.x = ($urandom_range(1) == 0) ? sb.vx[k] : COORD_BITS'($urandom_range(sb.vx[k]));
      b.w = COORD_BITS'($urandom_range(80));
      b.h = COORD_BITS'($urandom_range(80));
      b.y = ($urandom_range(1) == 0 || sb.vy[k] < b.h) ? sb.vy[k] : sb.vy[k] - b.h;
    end else if (mode < 88) begin
      b = box_t'({$urandom, $urandom});
    end else begin
      b.x = ($urandom_range(1) == 0) ? '0 : CMAX;
      b.y = ($urandom_range(1) == 0) ? '0 : CMAX;
      b.w = ($urandom_range(2) == 0) ? COORD_BITS'($urandom) : (($urandom_range(1) == 0) ? '0 : CMAX);
      b.h = ($urandom_range(2) == 0) ? COORD_BITS'($urandom) : (($urandom_range(1) == 0) ? '0 : CMAX);
    end
    return b;
  endfunction

  initial begin
    int qx [NUM_VERTS];
    int qy [NUM_VERTS];
    int p, n;

    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.box_x      = '0;
    in_ch.box_y      = '0;
    in_ch.box_width  = '0;
    in_ch.box_height = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opener against the reset quadrilateral: field extremes,
    // alternating bit patterns and corners sitting exactly on each vertex.
    send_box(mk_box(0, 0, 0, 0));
    send_box(mk_box(CMAX, CMAX, CMAX, CMAX));
    send_box(mk_box(0, 0, CMAX, CMAX));
    send_box(mk_box(CMAX, 0, 0, CMAX));
    send_box(mk_box(682, 341, 341, 682));
    send_box(mk_box(300, 200, 50, 50));
    send_box(mk_box(RST_V0_X, RST_V0_Y, 0, 0));
    send_box(mk_box(RST_V1_X, RST_V1_Y, 0, 0));
    send_box(mk_box(RST_V2_X, RST_V2_Y, 0, 0));
    send_box(mk_box(RST_V3_X, RST_V3_Y, 0, 0));
    send_box(mk_box(200, RST_V0_Y, 300, RST_V3_Y - RST_V0_Y));
    send_box(mk_box(0, RST_V1_Y, CMAX, 384));

    // Full-range square: corner sums reaching 1023 touch the right edge,
    // sums past it must not wrap back inside.
    wait_drained(PIPE_LATENCY);
    pick_quad(QUAD_SQUARE, qx, qy);
    set_quad(qx, qy);
    send_box(mk_box(0, 0, 0, 0));
    send_box(mk_box(1, 1, 1022, 1022));
    send_box(mk_box(512, 512, 511, 511));
    send_box(mk_box(512, 512, 512, 512));

    // Collapsed edge and an edge lying along the ray.
    wait_drained(PIPE_LATENCY);
    pick_quad(QUAD_FLAT, qx, qy);
    set_quad(qx, qy);
    send_box(mk_box(50, 500, 0, 0));
    send_box(mk_box(50, 700, 0, 0));
    send_box(mk_box(200, 500, 400, 0));

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained(PIPE_LATENCY);
      pick_quad(PHASE_QUAD[p], qx, qy);
      set_quad(qx, qy);
      case (p / 3)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long output stall while boxes keep coming: fill the pipe
        if (n == 60 && (p == 4 || p == 7)) hold_left = LONG_HOLD;
        // stop offering until the pipe has emptied completely
        if (n == 150) wait_drained(0);
        send_box(random_box());
      end
    end

    wait_drained(2 * PIPE_LATENCY);

    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
    end
    $display("Covered %0d boxes over %0d quadrilaterals (%0d register writes, some to unused indexes).",
             boxes_sent, quads_loaded, cfg_writes);
    $display("Checked %0d results, %0d with the box inside; %0d mismatches.",
             sb.checked, sb.inside_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rect_in_quad_ray_cast test passed");
    end else begin
      $display("rect_in_quad_ray_cast test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/riq_pkg.sv
hw/rtl/riq_ifs.sv
hw/rtl/riq_cfg_regs.sv
hw/rtl/rect_in_quad_ray_cast.sv
dv/riq_tb_pkg.sv
dv/tb_rect_in_quad_ray_cast.sv
